// ----- sv/turtle_pen_position_update_top_macros.svh -----
// assertion macros for the pen engine checker
`ifndef TURTLE_PEN_POSITION_UPDATE_TOP_MACROS_SVH
`define TURTLE_PEN_POSITION_UPDATE_TOP_MACROS_SVH
// a property that must hold at every clock edge out of reset
`define TPU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// a property checked at every clock edge, during reset too
`define TPU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- sv/tpu_pkg.sv -----
// ----------------------------------------------------------------------------
// tpu_pkg
// types, constants and tables shared by the pen engine
// ----------------------------------------------------------------------------
`default_nettype none
package tpu_pkg;
   localparam int CordicStagesDef = 16;
   localparam int FracBitsDef     = 8;
   localparam int AngFrac         = 20;
   localparam int TableLen        = 24;
   localparam int AngW            = 32;
   localparam int VecW            = 33;
   localparam logic signed [32:0] GainQ30 = 33'sd652032874;

   localparam logic [1:0] KIND_FORWARD = 2'd0;
   localparam logic [1:0] KIND_LEFT    = 2'd1;
   localparam logic [1:0] KIND_RIGHT   = 2'd2;

   localparam logic CSR_START_X = 1'b0;
   localparam logic CSR_START_Y = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [23:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
   } rsp_type;

   function automatic logic signed [31:0] atan_deg(input int i);
      logic signed [31:0] r;
      unique case (i)
         0: r = 32'sd47185920;   1: r = 32'sd27855475;  2: r = 32'sd14718068;
         3: r = 32'sd7471121;    4: r = 32'sd3750058;   5: r = 32'sd1876857;
         6: r = 32'sd938658;     7: r = 32'sd469357;    8: r = 32'sd234682;
         9: r = 32'sd117342;     10: r = 32'sd58671;    11: r = 32'sd29335;
         12: r = 32'sd14668;     13: r = 32'sd7334;     14: r = 32'sd3667;
         15: r = 32'sd1833;      16: r = 32'sd917;      17: r = 32'sd458;
         18: r = 32'sd229;       19: r = 32'sd115;      20: r = 32'sd57;
         21: r = 32'sd29;        22: r = 32'sd14;       23: r = 32'sd7;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh07FFFFFFF)       r = 32'sh7FFFFFFF;
      else if (v < -34'sh080000000) r = 32'sh80000000;
      else                          r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- sv/tpu_front.sv -----
// ----------------------------------------------------------------------------
// tpu_front
// accepts commands, tracks the heading and queues forward moves with angle
// ----------------------------------------------------------------------------
`default_nettype none
module tpu_front import tpu_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDef,
   parameter int HeadW     = FRAC_BITS + 9
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    q_valid,
   input  wire logic               q_pop,
   output logic signed [23:0]      q_amount,
   output logic [HeadW-1:0]        q_heading
);
   localparam int Depth = 4;
   localparam int Full = 360 << FRAC_BITS;
   localparam int HW2 = HeadW + 2;
   // a full turn is 45 << Sh
   localparam int Sh = FRAC_BITS + 3;
   localparam int Offset = (((1 << 23) + Full - 1) / Full) * Full;
   localparam logic [18:0] Recip45 = 19'd372828;

   logic [HeadW-1:0]  heading_ff, heading_in;
   logic [23:0]       amt_mem [Depth];
   logic [HeadW-1:0]  hd_mem  [Depth];
   logic [1:0]        wp_ff, rp_ff;
   logic [2:0]        cnt_ff;
   logic              acc, push;
   logic signed [HW2+24:0] t;
   logic [31:0]       u;
   logic [17:0]       v, rem;
   logic [36:0]       prod;
   logic [12:0]       q45;

   assign req_stall = (cnt_ff == 3'(Depth));
   assign acc  = req_valid && !req_stall;
   assign push = acc && req_data.kind == KIND_FORWARD;

   // shift to non-negative by whole turns, then reduce the bits above the
   // power of two modulo 45 with a reciprocal multiply
   always_comb begin
      t = (req_data.kind == KIND_LEFT) ?
          $signed({1'b0, heading_ff}) + req_data.amount :
          $signed({1'b0, heading_ff}) - req_data.amount;
      u = 32'(t + (HW2+25)'(Offset));
      v = 18'(u >> Sh);
      prod = 37'(v) * 37'(Recip45);
      q45 = prod[36:24];
      rem = v - 18'(q45) * 18'd45;
      heading_in = heading_ff;
      if (acc && (req_data.kind == KIND_LEFT || req_data.kind == KIND_RIGHT))
         heading_in = {rem[5:0], u[Sh-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= HeadW'(180) << FRAC_BITS;
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         heading_ff <= heading_in;
         if (push) begin
            amt_mem[wp_ff] <= req_data.amount;
            hd_mem[wp_ff]  <= heading_ff;
            wp_ff <= wp_ff + 2'd1;
         end
         if (q_pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(q_pop);
      end
   end

   assign q_valid   = cnt_ff != 3'd0;
   assign q_amount  = amt_mem[rp_ff];
   assign q_heading = hd_mem[rp_ff];
endmodule
`default_nettype wire

// ----- sv/tpu_cordic.sv -----
// ----------------------------------------------------------------------------
// tpu_cordic
// pipelined rotation cordic giving amount*sin and amount*cos of a heading
// ----------------------------------------------------------------------------
`default_nettype none
module tpu_cordic import tpu_pkg::*; #(
   parameter int CORDIC_STAGES = CordicStagesDef,
   parameter int FRAC_BITS     = FracBitsDef,
   parameter int HeadW         = FRAC_BITS + 9
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic signed [23:0] in_amount,
   input  wire logic [HeadW-1:0]  in_heading,
   output logic                   out_valid,
   output logic signed [31:0]     out_dx,
   output logic signed [31:0]     out_dy
);
   localparam int N = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
   localparam int L = N + 3;
   localparam logic signed [AngW-1:0] Q = AngW'(90) <<< AngFrac;

   logic signed [VecW-1:0] x_ff [L];
   logic signed [VecW-1:0] y_ff [L];
   logic signed [AngW-1:0] z_ff [L];
   logic signed [23:0]     a_ff [L];
   logic                   n_ff [L];
   logic                   v_ff [L];
   logic signed [56:0]     ms_ff, mc_ff;
   logic signed [AngW-1:0] ang;

   assign ang = AngW'(in_heading) <<< (AngFrac - FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < L; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= GainQ30; y_ff[0] <= '0; a_ff[0] <= in_amount;
         if (ang <= Q) begin
            z_ff[0] <= ang; n_ff[0] <= 1'b0;
         end else if (ang < 3*Q) begin
            z_ff[0] <= ang - 2*Q; n_ff[0] <= 1'b1;
         end else begin
            z_ff[0] <= ang - 4*Q; n_ff[0] <= 1'b0;
         end
         for (int i = 0; i < N; i++) begin
            a_ff[i+1] <= a_ff[i]; n_ff[i+1] <= n_ff[i];
            if (!z_ff[i][AngW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_deg(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_deg(i);
            end
         end
         // sign fix and product
         x_ff[N+1] <= n_ff[N] ? -x_ff[N] : x_ff[N];
         y_ff[N+1] <= n_ff[N] ? -y_ff[N] : y_ff[N];
         a_ff[N+1] <= a_ff[N];
         ms_ff <= a_ff[N+1] * y_ff[N+1] + (57'sd1 <<< 29);
         mc_ff <= a_ff[N+1] * x_ff[N+1] + (57'sd1 <<< 29);
         x_ff[N+2] <= '0; y_ff[N+2] <= '0; z_ff[N+1] <= '0; z_ff[N+2] <= '0;
         a_ff[N+2] <= '0; n_ff[N+1] <= 1'b0; n_ff[N+2] <= 1'b0;
      end
   end

   // product >> 30 fits in 27 bits
   assign out_valid = v_ff[N+2];
   assign out_dx = {{5{ms_ff[56]}}, ms_ff[56:30]};
   assign out_dy = {{5{mc_ff[56]}}, mc_ff[56:30]};
endmodule
`default_nettype wire

// ----- sv/tpu_back.sv -----
// ----------------------------------------------------------------------------
// tpu_back
// pen accumulator: adds deltas to the pen position and holds the result
// ----------------------------------------------------------------------------
`default_nettype none
module tpu_back import tpu_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDef
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [0:0]        csr_sel,
   input  wire logic              csr_hit,
   input  wire logic [31:0]       csr_data,
   input  wire logic              d_valid,
   input  wire logic signed [31:0] d_x,
   input  wire logic signed [31:0] d_y,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data
);
   localparam logic signed [31:0] StartX = 32'(640 / 2) << FRAC_BITS;
   localparam logic signed [31:0] StartY = 32'(480 / 2) << FRAC_BITS;

   logic signed [31:0] pen_x_ff, pen_y_ff, nx, ny;
   rsp_type            out_ff;
   logic               v_ff;

   assign nx = sat32(34'(pen_x_ff) + 34'(d_x));
   assign ny = sat32(34'(pen_y_ff) + 34'(d_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= StartX; pen_y_ff <= StartY; v_ff <= 1'b0;
      end else begin
         if (csr_write && csr_hit) begin
            if (csr_sel == CSR_START_X) pen_x_ff <= csr_data;
            else                        pen_y_ff <= csr_data;
         end else if (d_valid) begin
            pen_x_ff <= nx; pen_y_ff <= ny;
            out_ff <= '{pen_x_ff, pen_y_ff, nx, ny};
         end
         if (d_valid) v_ff <= 1'b1;
         else if (!rsp_stall) v_ff <= 1'b0;
      end
   end

   assign rsp_valid = v_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

// ----- sv/turtle_pen_position_update_top.sv -----
// ----------------------------------------------------------------------------
// turtle_pen_position_update_top
// pen engine: heading tracker, pipelined cordic and pen accumulator
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | kind, amount
// rsp     | out | from_x, from_y, to_x, to_y
// csr     | in  | start_x, start_y write
// one command per cycle while the queue has room; forward moves pass through
// the cordic pipeline, which advances only when rsp is free
// turns finish in the cycle they are accepted
// synchronous reset; a four-entry queue decouples front and back
`default_nettype none
module turtle_pen_position_update_top import tpu_pkg::*; #(
   parameter int CORDIC_STAGES = CordicStagesDef,
   parameter int FRAC_BITS     = FracBitsDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int HeadW = FRAC_BITS + 9;
   logic q_valid, q_pop, en, c_valid;
   logic signed [23:0] q_amount;
   logic [HeadW-1:0]   q_heading;
   logic signed [31:0] dx, dy;

   // pipeline moves unless a held result would be overwritten
   assign en    = !(rsp_valid && rsp_stall);
   assign q_pop = en && q_valid;

   tpu_front #(.FRAC_BITS(FRAC_BITS), .HeadW(HeadW)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_pop, .q_amount, .q_heading);

   tpu_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS),
                .HeadW(HeadW)) u_cordic (
      .clock, .reset, .en, .in_valid(q_valid), .in_amount(q_amount),
      .in_heading(q_heading), .out_valid(c_valid), .out_dx(dx), .out_dy(dy));

   tpu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .csr_write, .csr_sel(csr_index), .csr_hit(1'b1),
      .csr_data, .d_valid(c_valid && en), .d_x(dx), .d_y(dy),
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule
`default_nettype wire

// ----- sv/tpu_checker.sv -----
// ----------------------------------------------------------------------------
// tpu_checker
// port-level checks on the pen engine
// ----------------------------------------------------------------------------
`default_nettype none
`include "turtle_pen_position_update_top_macros.svh"
module tpu_checker import tpu_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   `TPU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")
   `TPU_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result after reset")
   `TPU_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> !req_stall, "stall after reset")
endmodule
bind turtle_pen_position_update_top tpu_checker u_chk (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data);
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives pen commands with random idling and stalls, predicts each segment
// with a bit-exact cordic model and checks every field of every segment
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
import tpu_pkg::*;

class segment_board;
   rsp_type    pending[$];
   logic [16:0] heading;
   logic signed [31:0] pen_x, pen_y;
   int         errors, checked;

   function new();
      errors = 0;
      checked = 0;
      heading = 17'd46080;
      pen_x = 32'sd81920;
      pen_y = 32'sd61440;
   endfunction

   function longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function void set_start(logic idx, logic [31:0] v);
      if (idx == CSR_START_X) pen_x = v;
      else pen_y = v;
   endfunction

   function void sin_cos(output longint sn, output longint cs);
      longint q, a, x, y, z, dx, dy;
      bit neg;
      q = longint'(90) << 20;
      a = longint'(heading) << 12;
      x = 652032874;
      y = 0;
      neg = 0;
      if (a <= q) z = a;
      else if (a < 3 * q) begin
         z = a - 2 * q;
         neg = 1;
      end else z = a - 4 * q;
      for (int i = 0; i < 16; i++) begin
         dx = shr(y, i);
         dy = shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_deg(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_deg(i));
         end
      end
      cs = neg ? -x : x;
      sn = neg ? -y : y;
   endfunction

   function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function void note_command(req_type r);
      longint t, amt, sn, cs, nx, ny;
      rsp_type e;
      amt = longint'(r.amount);
      if (r.kind == KIND_LEFT || r.kind == KIND_RIGHT) begin
         t = (r.kind == KIND_LEFT) ? longint'(heading) + amt : longint'(heading) - amt;
         t = t % 92160;
         if (t < 0) t += 92160;
         heading = t[16:0];
      end else if (r.kind == KIND_FORWARD) begin
         sin_cos(sn, cs);
         nx = clip(longint'(pen_x) + shr(amt * sn + (longint'(1) << 29), 30));
         ny = clip(longint'(pen_y) + shr(amt * cs + (longint'(1) << 29), 30));
         e.from_x = pen_x;
         e.from_y = pen_y;
         e.to_x = nx[31:0];
         e.to_y = ny[31:0];
         pending.push_back(e);
         pen_x = nx[31:0];
         pen_y = ny[31:0];
      end
   endfunction

   function void check_segment(rsp_type a);
      rsp_type e;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected segment %h", a);
         return;
      end
      e = pending.pop_front();
      if (a !== e) begin
         errors++;
         if (errors <= 10)
            $display("segment mismatch: exp from(%0d,%0d) to(%0d,%0d) got from(%0d,%0d) to(%0d,%0d)",
               e.from_x, e.from_y, e.to_x, e.to_y, a.from_x, a.from_y, a.to_x, a.to_y);
      end
   endfunction
endclass

module testbench;
   localparam logic [1:0] KindUnused = 2'd3;

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   logic    csr_write;
   logic [0:0] csr_index;
   logic [31:0] csr_data;
   int      idle_pct, stall_pct, sent;
   segment_board board;

   turtle_pen_position_update_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

   // result side: random stall, check at the rising edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_segment(rsp_data);
         if (req_valid && !req_stall) board.note_command(req_data);
      end
   end

   // valid stays high between back-to-back transactions
   task automatic send(logic [1:0] k, logic [23:0] amt);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.kind <= k;
      req_data.amount <= amt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      while (n < 40) begin
         @(negedge clock);
         n++;
      end
   endtask

   task automatic write_start(logic idx, logic [31:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      board.set_start(idx, v);
      @(negedge clock);
   endtask

   task automatic random_burst(int n);
      logic [1:0] k;
      logic [23:0] a;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99) < 50 ? KIND_FORWARD : 2'($urandom_range(2));
         if ($urandom_range(99) < 3) k = KindUnused;
         if ($urandom_range(99) < 10) a = 24'($urandom);
         else a = 24'($urandom_range(100000) - 50000);
         send(k, a);
      end
   endtask

   initial begin
      board = new();
      reset = 1; req_valid = 0; req_data = '0; rsp_stall = 0;
      csr_write = 0; csr_index = 0; csr_data = 0;
      idle_pct = 0; stall_pct = 0; sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: all kinds, extremes, negative amounts, unused kind, saturation
      send(KIND_FORWARD, 24'd2560);
      send(KIND_LEFT, 24'd23040);
      send(KIND_FORWARD, 24'h7FFFFF);
      send(KIND_RIGHT, 24'd11520);
      send(KIND_FORWARD, 24'h800000);
      send(KIND_LEFT, 24'h800000);
      send(KIND_FORWARD, -24'sd1000);
      send(KIND_RIGHT, 24'h7FFFFF);
      send(KIND_FORWARD, 24'd0);
      send(KindUnused, 24'hFFFFFF);
      send(KIND_RIGHT, -24'sd5000);
      send(KIND_FORWARD, 24'd700);
      drain();
      write_start(CSR_START_X, 32'h7FFFFF00);
      write_start(CSR_START_Y, 32'h80000000);
      send(KIND_LEFT, 24'd23040);
      send(KIND_FORWARD, 24'h7FFFFF);
      send(KIND_RIGHT, 24'd46080);
      send(KIND_FORWARD, 24'h7FFFFF);
      send(KIND_LEFT, 24'd11520);
      send(KIND_FORWARD, 24'h800000);
      drain();
      write_start(CSR_START_X, 32'h80000000);
      write_start(CSR_START_Y, 32'h7FFFFFFF);
      send(KIND_FORWARD, 24'h800000);
      send(KIND_FORWARD, 24'h7FFFFF);
      random_burst(250);
      drain();
      write_start(CSR_START_X, $urandom);
      write_start(CSR_START_Y, $urandom);
      idle_pct = 74;
      random_burst(250);
      drain();
      idle_pct = 0; stall_pct = 74;
      random_burst(250);
      drain();
      write_start(CSR_START_X, 32'd81920);
      write_start(CSR_START_Y, 32'd61440);
      idle_pct = 30; stall_pct = 30;
      random_burst(300);
      idle_pct = 0; stall_pct = 0;
      drain();
      $display("covered %0d commands and %0d segments over four idle/stall mixes",
         sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
